@@ design/bpa_pkg.sv @@
package bpa_pkg;

    localparam int BITMAP_BYTES = 128;
    localparam int SLOT_TOTAL   = BITMAP_BYTES * 8;
    localparam int ADDR_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int COUNT_W      = $clog2(SLOT_TOTAL + 1);

    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef enum logic [1:0]
    {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DONE
    } state_t;

    // position of the lowest clear bit; caller guarantees one exists
    function automatic logic [2:0] lowest_zero(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!b[k])
            begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

endpackage

@@ design/bitmap_page_allocator_top.sv @@
// First-free page slot allocator over a bitmap of BITMAP_BYTES bytes (eight slots per
// byte, slot s at byte s/8 bit s%8) plus a used-slot counter. Each request transaction
// (allocate, free, query, unused kind) yields exactly one result transaction carrying
// success, the allocated slot and the used count after the request. The input side
// stalls while a request is in work. An in-range free or query does one bitmap memory
// read and one check/write step, then loads the output register. Allocate walks the
// bitmap memory one byte per cycle from byte 0 until it finds a byte with a clear bit
// or reaches the last byte; an allocate on a full bitmap fails without a scan. A
// result that is stalled at the output holds the next result in the sequencer. After
// reset every slot reads free at once: per-byte valid flops mask bytes never written,
// no clearing pass.
module bitmap_page_allocator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [9:0]  page_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    output logic [9:0]  found_page,
    output logic [10:0] used_count
);
    import bpa_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_BYTES - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    kind_t               kind_reg, kind_next;
    logic [2:0]          bit_reg, bit_next;
    logic                succ_reg, succ_next;
    logic [9:0]          found_reg, found_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic                success_reg;
    logic [9:0]          found_page_reg;
    logic [10:0]         used_count_reg;

    logic [7:0]          bitmap_mem [BITMAP_BYTES];
    logic [7:0]          rd_data_reg;
    logic [BITMAP_BYTES-1:0] entry_valid_reg;
    logic                rvalid_reg;

    logic [7:0]          byte_val;
    logic                wr_en;
    logic [7:0]          wr_data;
    logic [2:0]          zero_pos;
    logic                in_fire;
    logic                out_free;
    logic                is_full;
    logic                out_of_range;
    logic                slot_used;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign byte_val  = rvalid_reg ? rd_data_reg : 8'h00;
    assign zero_pos  = lowest_zero(byte_val);
    assign slot_used = byte_val[bit_reg];
    assign is_full   = (32'(count_reg) >= SLOT_TOTAL);
    assign out_of_range = (32'(page_index) >= SLOT_TOTAL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (kind == KIND_ALLOC)
                    begin
                        state_next = is_full ? S_DONE : S_SCAN;
                    end
                    else if (kind == KIND_FREE || kind == KIND_QUERY)
                    begin
                        state_next = out_of_range ? S_DONE : S_CHECK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (byte_val != BYTE_FULL || addr_reg == LAST_ADDR)
                begin
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        bit_next       = bit_reg;
        succ_next      = succ_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_data        = byte_val;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next  = kind_t'(kind);
                    bit_next   = page_index[2:0];
                    succ_next  = 1'b0;
                    found_next = 10'd0;
                    addr_next  = (kind == KIND_ALLOC) ? '0 : ADDR_W'(page_index >> 3);
                end
            end
            S_SCAN:
            begin
                if (byte_val != BYTE_FULL)
                begin
                    wr_en      = 1'b1;
                    wr_data    = byte_val | (8'b1 << zero_pos);
                    succ_next  = 1'b1;
                    found_next = 10'({addr_reg, zero_pos});
                    count_next = count_reg + 1'b1;
                end
                else if (addr_reg != LAST_ADDR)
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (kind_reg == KIND_FREE)
                begin
                    if (slot_used)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = byte_val & ~(8'b1 << bit_reg);
                        succ_next = 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    succ_next = !slot_used;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        kind_reg  <= kind_next;
        bit_reg   <= bit_next;
        succ_reg  <= succ_next;
        found_reg <= found_next;
        if (state_reg == S_DONE && out_free)
        begin
            success_reg    <= succ_reg;
            found_page_reg <= found_reg;
            used_count_reg <= 11'(count_reg);
        end
    end

    // bitmap memory: read data is registered from addr_next, so it lines up with addr_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[addr_reg] <= wr_data;
        end
        rd_data_reg <= bitmap_mem[addr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rvalid_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[addr_reg] <= 1'b1;
            end
            rvalid_reg <= entry_valid_reg[addr_next];
        end
    end

    assign out_valid  = out_valid_reg;
    assign success    = success_reg;
    assign found_page = found_page_reg;
    assign used_count = used_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= SLOT_TOTAL)
        else $error("used count above slot total");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SCAN || state_reg == S_CHECK))
        else $error("bitmap write outside scan or check");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && wr_en) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("allocate did not bump used count");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after completion");

    a_alloc_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && wr_en) |-> (wr_data != byte_val && (wr_data & ~byte_val) != 8'h00))
        else $error("allocate write did not set a clear bit");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SHOWN_MAX   = 40;

    class slot_ledger;

        typedef struct packed
        {
            logic        ok;
            logic [9:0]  page;
            logic [10:0] count;
        } grant_t;

        logic [7:0]  slot_map [BITMAP_BYTES];
        int unsigned slots_taken;
        grant_t      awaited_grants [$];
        int          errors;

        function new();
            foreach (slot_map[b])
            begin
                slot_map[b] = 8'h00;
            end
            slots_taken = 0;
            errors      = 0;
        endfunction

        function logic is_taken(int s);
            return slot_map[s / 8][s % 8];
        endfunction

        // advance the shadow bitmap by one accepted request and queue its outcome
        function void note_request(kind_t op, logic [9:0] idx);
            grant_t g;
            int     hit;
            g   = '0;
            hit = -1;
            case (op)
                KIND_ALLOC:
                begin
                    if (slots_taken < SLOT_TOTAL)
                    begin
                        for (int s = 0; s < SLOT_TOTAL && hit < 0; s++)
                        begin
                            if (!is_taken(s))
                            begin
                                hit = s;
                            end
                        end
                    end
                    if (hit >= 0)
                    begin
                        slot_map[hit / 8][hit % 8] = 1'b1;
                        slots_taken++;
                        g.ok   = 1'b1;
                        g.page = 10'(hit);
                    end
                end
                KIND_FREE:
                begin
                    if (int'(idx) < SLOT_TOTAL && is_taken(int'(idx)))
                    begin
                        slot_map[idx >> 3][idx[2:0]] = 1'b0;
                        if (slots_taken > 0)
                        begin
                            slots_taken--;
                        end
                        g.ok = 1'b1;
                    end
                end
                KIND_QUERY:
                begin
                    g.ok = (int'(idx) < SLOT_TOTAL) && !is_taken(int'(idx));
                end
                default:
                begin
                end
            endcase
            g.count = 11'(slots_taken);
            awaited_grants.push_back(g);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= SHOWN_MAX)
            begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
        endtask

        task check_result(logic ok, logic [9:0] page, logic [10:0] count);
            grant_t want;
            if (awaited_grants.size() == 0)
            begin
                report($sformatf("unexpected result ok=%b page=%0d count=%0d", ok, page, count));
                return;
            end
            want = awaited_grants.pop_front();
            if (ok !== want.ok)
            begin
                report($sformatf("success %b, want %b", ok, want.ok));
            end
            if (page !== want.page)
            begin
                report($sformatf("found_page %0d, want %0d", page, want.page));
            end
            if (count !== want.count)
            begin
                report($sformatf("used_count %0d, want %0d", count, want.count));
            end
        endtask

    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  kind       = KIND_ALLOC;
    logic [9:0]  page_index = 10'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        success;
    logic [9:0]  found_page;
    logic [10:0] used_count;

    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         cycles        = 0;
    slot_ledger ledger        = new();

    bitmap_page_allocator_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .page_index (page_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .success    (success),
        .found_page (found_page),
        .used_count (used_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // results first: a request never completes in the cycle it is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                ledger.check_result(success, found_page, used_count);
            end
            if (in_valid && !in_stall)
            begin
                ledger.note_request(kind_t'(kind), page_index);
            end
        end
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task send_request(kind_t op, logic [9:0] idx);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        page_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // slots in use sit low, so most targets are drawn near the allocated region
    function logic [9:0] pick_slot();
        int hi;
        hi = ledger.slots_taken + 8;
        if (hi > 1023)
        begin
            hi = 1023;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            return 10'($urandom_range(0, 1023));
        end
        return 10'($urandom_range(0, hi));
    endfunction

    task random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            send_request(KIND_ALLOC, 10'($urandom_range(0, 1023)));
        end
        else if (r < 70)
        begin
            send_request(KIND_FREE, pick_slot());
        end
        else if (r < 95)
        begin
            send_request(KIND_QUERY, pick_slot());
        end
        else
        begin
            send_request(KIND_NONE, 10'($urandom_range(0, 1023)));
        end
    endtask

    task drain();
        in_valid <= 1'b0;
        while (ledger.awaited_grants.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int fill;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty bitmap, field extremes, unused kind, double free
        send_request(KIND_QUERY, 10'd0);
        send_request(KIND_QUERY, 10'd1023);
        send_request(KIND_QUERY, 10'h2AA);
        send_request(KIND_QUERY, 10'h155);
        send_request(KIND_FREE, 10'd0);
        send_request(KIND_FREE, 10'd1023);
        send_request(KIND_NONE, 10'd1023);
        send_request(KIND_NONE, 10'd0);
        send_request(KIND_ALLOC, 10'd1023);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'h2AA);
        send_request(KIND_QUERY, 10'd1);
        send_request(KIND_FREE, 10'd1);
        send_request(KIND_QUERY, 10'd1);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_FREE, 10'd2);
        send_request(KIND_FREE, 10'd2);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_FREE, 10'd0);
        send_request(KIND_FREE, 10'd1);
        send_request(KIND_FREE, 10'd2);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_QUERY, 10'd0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (150) random_request();
        end

        // fill the bitmap to the top, then work around the full state
        send_idle_pct = 0;
        stall_pct     = 0;
        drain();
        @(posedge clk);
        fill = SLOT_TOTAL - ledger.slots_taken;
        repeat (fill) send_request(KIND_ALLOC, 10'($urandom_range(0, 1023)));
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_QUERY, 10'd1023);
        send_request(KIND_FREE, 10'd517);
        send_request(KIND_QUERY, 10'd517);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd1023);
        send_request(KIND_FREE, 10'd1023);
        send_request(KIND_FREE, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_FREE, 10'd1023);
        send_request(KIND_QUERY, 10'd1023);

        drain();
        repeat (BITMAP_BYTES + 16) @(posedge clk);
        if (ledger.errors == 0 && ledger.awaited_grants.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ bitmap_page_allocator_top.f @@
design/bpa_pkg.sv
design/bitmap_page_allocator_top.sv
tb/sv/tb.sv
